// File: rtl/core/mmrb_pkg.sv
// Shared types, constants and helpers of the multicast message ring buffer.
`default_nettype none
package mmrb_pkg;
    localparam int RING_BYTES   = 4096;
    localparam int AW           = $clog2(RING_BYTES);
    localparam int FW           = AW + 1;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_READERS  = 8;
    localparam int RDW          = 3;
    localparam int CNTW         = 4;
    localparam int LENW         = 12;
    localparam int CHUNKW       = 9;
    localparam int SPANW        = 13;

    localparam logic [0:0] CFG_CHUNK_SIZE     = 1'd0;
    localparam logic [0:0] CFG_CONSUMER_COUNT = 1'd1;

    typedef enum logic [1:0] {
        CMD_PUSH_BEGIN = 2'd0,
        CMD_PUSH_DATA  = 2'd1,
        CMD_POP_BEGIN  = 2'd2,
        CMD_POP_DATA   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_WRAPPED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_READY    = 3'd3,
        ST_DUMMY    = 3'd4,
        ST_DATA     = 3'd5,
        ST_PHASE    = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_DIV, S_PB_DEC, S_HDR_WR, S_PUSH_WR,
        S_HDR_RD, S_POP_DEC, S_PD_RD, S_PD_CAP, S_OUT
    } t_state;

    // header: id(2) length(2) padding(2) reader count(1), rest zero
    function automatic logic [7:0] hdr_byte(input logic [3:0] k, input logic [15:0] id,
                                            input logic [15:0] len, input logic [15:0] pad,
                                            input logic [7:0] cnt);
        logic [7:0] b;
        unique case (k)
            4'd0:    b = id[7:0];
            4'd1:    b = id[15:8];
            4'd2:    b = len[7:0];
            4'd3:    b = len[15:8];
            4'd4:    b = pad[7:0];
            4'd5:    b = pad[15:8];
            4'd6:    b = cnt;
            default: b = 8'd0;
        endcase
        return b;
    endfunction
endpackage
`default_nettype wire

// File: rtl/core/mmrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mmrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/mmrb_rem.sv
// Bit-serial remainder unit: dividend modulo chunk size, one bit a cycle.
`default_nettype none
module mmrb_rem (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_start,
    input  wire [mmrb_pkg::SPANW-1:0]       i_dividend,
    input  wire [mmrb_pkg::CHUNKW-1:0]      i_divisor,
    output logic                            o_done,
    output logic [mmrb_pkg::CHUNKW-1:0]     o_rem
);
    logic [mmrb_pkg::SPANW-1:0]  r_q;
    logic [mmrb_pkg::CHUNKW:0]   r_rem;
    logic [mmrb_pkg::CHUNKW-1:0] r_div;
    logic [3:0]                  r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [mmrb_pkg::CHUNKW:0]   n_trial;

    always_comb begin
        n_trial = {r_rem[mmrb_pkg::CHUNKW-1:0], r_q[mmrb_pkg::SPANW-1]};
        if (n_trial >= {1'b0, r_div}) begin
            n_trial = n_trial - {1'b0, r_div};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'(mmrb_pkg::SPANW);
                r_q    <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_trial;
                r_q   <= {r_q[mmrb_pkg::SPANW-2:0], 1'b0};
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[mmrb_pkg::CHUNKW-1:0];
endmodule
`default_nettype wire

// File: rtl/core/multicast_message_ring_buffer.sv
// Top level of the multicast message ring buffer: sequencer around the byte ring.
//
// channel   dir  handshake                      contents
// s_axis    in   s_axis_tvalid/s_axis_tready    cmd, msg_length, reader, byte_in
// m_axis    out  m_axis_tvalid/m_axis_tready    status, out_length, byte_out, free_now; tlast
// cfg       in   i_cfg_we                       chunk_size (0), consumer_count (1)
//
// One request at a time. pop_data reads one byte, and on the last byte also re-reads the header
// (header re-read over the single RAM read port). pop_begin reads the header back;
// push_begin runs the bit-serial remainder and then writes the header bytes.
// Reset is synchronous; ring contents are not cleared. A result held on m_axis does
// not block the next request until that request's own result is ready.
`default_nettype none
module multicast_message_ring_buffer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // cmd[1:0] msg_length[13:2] reader[16:14] byte_in[24:17]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // status[2:0] out_length[14:3] byte_out[22:15]
                                        // free_now[35:23]
    output logic        m_axis_tlast,
    input  wire         i_cfg_we,
    input  wire  [0:0]  i_cfg_addr,
    input  wire  [8:0]  i_cfg_wdata
);
    localparam int AW = mmrb_pkg::AW;
    localparam int FW = mmrb_pkg::FW;

    mmrb_pkg::t_state  r_state, n_state;
    mmrb_pkg::t_cmd    r_cmd;
    mmrb_pkg::t_status r_status;

    logic [mmrb_pkg::CHUNKW-1:0] r_chunk;
    logic [mmrb_pkg::CNTW-1:0]   r_ccount;
    logic [mmrb_pkg::LENW-1:0]   r_len;
    logic [mmrb_pkg::RDW-1:0]    r_rd;
    logic [7:0]                  r_b;

    logic [AW-1:0]  r_wpos, r_rel, r_push_cur, r_push_left, r_hbase;
    logic [FW-1:0]  r_free;
    logic [15:0]    r_msgc;
    logic [mmrb_pkg::SPANW-1:0] r_push_span;
    logic [AW-1:0]  r_read_pos [mmrb_pkg::MAX_READERS];
    logic [AW-1:0]  r_pop_cur  [mmrb_pkg::MAX_READERS];
    logic [AW-1:0]  r_pop_left [mmrb_pkg::MAX_READERS];

    logic [3:0]  r_k;
    logic [15:0] r_h_id, r_h_len, r_h_pad;
    logic [7:0]  r_h_cnt;
    logic [15:0] r_f_id, r_f_len, r_f_pad;
    logic [7:0]  r_f_cnt;

    logic [mmrb_pkg::LENW-1:0] r_olen;
    logic [7:0]                r_ob;
    logic                      r_last;
    logic                      r_m_valid;
    logic [39:0]               r_m_data;
    logic                      r_m_last;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    logic [7:0]                ram_wdata, ram_rdata;

    logic                      div_start, div_done;
    logic [mmrb_pkg::CHUNKW-1:0] div_rem;

    logic [mmrb_pkg::CHUNKW-1:0] chunk_eff, pad;
    logic [mmrb_pkg::CNTW-1:0]   readers_eff;
    logic                        reader_ok;
    logic [mmrb_pkg::SPANW-1:0]  span, tail;
    logic [7:0]                  cnt_dec;
    logic [16:0]                 f_span;
    logic [AW-1:0]               f_next;
    logic [17:0]                 free_sum;
    logic [FW-1:0]               free_sat;
    logic                        pb_dummy_pop, pb_plain_pop;

    mmrb_ram #(.WIDTH(8), .DEPTH(mmrb_pkg::RING_BYTES)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mmrb_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (13'(r_len) + 13'(mmrb_pkg::HEADER_BYTES)),
        .i_divisor  (chunk_eff),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_comb begin
        chunk_eff   = (r_chunk == '0) ? 9'd1 : r_chunk;
        readers_eff = (r_ccount == '0) ? 4'd1
                    : (r_ccount > 4'(mmrb_pkg::MAX_READERS)) ? 4'(mmrb_pkg::MAX_READERS)
                    : r_ccount;
        reader_ok   = {1'b0, r_rd} < readers_eff;
        pad         = (div_rem == '0) ? '0 : chunk_eff - div_rem;
        span        = 13'(r_len) + 13'(mmrb_pkg::HEADER_BYTES) + 13'(pad);
        tail        = 13'(mmrb_pkg::RING_BYTES) - 13'(r_wpos);
        cnt_dec     = (r_f_cnt != 8'd0) ? r_f_cnt - 8'd1 : 8'd0;
        f_span      = 17'(mmrb_pkg::HEADER_BYTES) + 17'(r_f_len) + 17'(r_f_pad);
        f_next      = r_hbase + f_span[AW-1:0];
        pb_dummy_pop = (r_cmd == mmrb_pkg::CMD_POP_BEGIN) && (r_f_id == 16'd0);
        pb_plain_pop = (r_cmd == mmrb_pkg::CMD_POP_BEGIN) && (r_f_id != 16'd0)
                    && (r_f_len[mmrb_pkg::LENW-1:0] != '0);
        if (pb_dummy_pop) begin
            free_sum = 18'(r_free) + 18'(mmrb_pkg::RING_BYTES) - 18'(r_hbase);
        end else begin
            free_sum = 18'(r_free) + 18'(f_span);
        end
        free_sat = (free_sum > 18'(mmrb_pkg::RING_BYTES)) ? FW'(mmrb_pkg::RING_BYTES)
                 : free_sum[FW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmrb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_hbase + AW'(r_k);
        ram_wdata = mmrb_pkg::hdr_byte(r_k, r_h_id, r_h_len, r_h_pad, r_h_cnt);
        ram_raddr = r_hbase + AW'(r_k);
        unique case (r_state)
            mmrb_pkg::S_IDLE: begin
                if (s_axis_tvalid) n_state = mmrb_pkg::S_DISPATCH;
            end
            mmrb_pkg::S_DISPATCH: begin
                n_state = mmrb_pkg::S_OUT;
                unique case (r_cmd)
                    mmrb_pkg::CMD_PUSH_BEGIN: begin
                        if (r_push_left == '0) begin
                            div_start = 1'b1;
                            n_state   = mmrb_pkg::S_DIV;
                        end
                    end
                    mmrb_pkg::CMD_PUSH_DATA: begin
                        if (r_push_left != '0) n_state = mmrb_pkg::S_PUSH_WR;
                    end
                    mmrb_pkg::CMD_POP_BEGIN: begin
                        if (reader_ok && r_pop_left[r_rd] == '0
                            && r_read_pos[r_rd] != r_wpos) n_state = mmrb_pkg::S_HDR_RD;
                    end
                    default: begin
                        if (reader_ok && r_pop_left[r_rd] != '0) n_state = mmrb_pkg::S_PD_RD;
                    end
                endcase
            end
            mmrb_pkg::S_DIV: begin
                if (div_done) n_state = mmrb_pkg::S_PB_DEC;
            end
            mmrb_pkg::S_PB_DEC: begin
                if (14'(span) + 14'(mmrb_pkg::HEADER_BYTES) > 14'(tail)) begin
                    n_state = (r_rel != '0 && tail <= r_free) ? mmrb_pkg::S_HDR_WR
                                                              : mmrb_pkg::S_OUT;
                end else begin
                    n_state = (14'(span) + 14'd1 < 14'(r_free)) ? mmrb_pkg::S_HDR_WR
                                                                : mmrb_pkg::S_OUT;
                end
            end
            mmrb_pkg::S_HDR_WR: begin
                ram_we = 1'b1;
                if (r_k == 4'(mmrb_pkg::HEADER_BYTES - 1)) n_state = mmrb_pkg::S_OUT;
            end
            mmrb_pkg::S_PUSH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_push_cur;
                ram_wdata = r_b;
                n_state   = mmrb_pkg::S_OUT;
            end
            mmrb_pkg::S_HDR_RD: begin
                if (r_k == 4'd7) n_state = mmrb_pkg::S_POP_DEC;
            end
            mmrb_pkg::S_POP_DEC: begin
                ram_we    = !pb_plain_pop;
                ram_waddr = r_hbase + AW'(6);
                ram_wdata = cnt_dec;
                n_state   = mmrb_pkg::S_OUT;
            end
            mmrb_pkg::S_PD_RD: begin
                ram_raddr = r_pop_cur[r_rd];
                n_state   = mmrb_pkg::S_PD_CAP;
            end
            mmrb_pkg::S_PD_CAP: begin
                n_state = (r_pop_left[r_rd] == AW'(1)) ? mmrb_pkg::S_HDR_RD : mmrb_pkg::S_OUT;
            end
            mmrb_pkg::S_OUT: begin
                if (!r_m_valid || m_axis_tready) n_state = mmrb_pkg::S_IDLE;
            end
            default: n_state = mmrb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk  <= 9'd16;
            r_ccount <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                mmrb_pkg::CFG_CHUNK_SIZE:     r_chunk  <= i_cfg_wdata;
                mmrb_pkg::CFG_CONSUMER_COUNT: r_ccount <= i_cfg_wdata[mmrb_pkg::CNTW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos      <= '0;
            r_rel       <= '0;
            r_free      <= FW'(mmrb_pkg::RING_BYTES);
            r_msgc      <= 16'd1;
            r_push_cur  <= '0;
            r_push_left <= '0;
            r_m_valid   <= 1'b0;
            r_k         <= '0;
            for (int i = 0; i < mmrb_pkg::MAX_READERS; i++) begin
                r_read_pos[i] <= '0;
                r_pop_cur[i]  <= '0;
                r_pop_left[i] <= '0;
            end
        end else begin
            if (r_m_valid && m_axis_tready) r_m_valid <= 1'b0;
            unique case (r_state)
                mmrb_pkg::S_IDLE: begin
                    r_cmd    <= mmrb_pkg::t_cmd'(s_axis_tdata[1:0]);
                    r_len    <= s_axis_tdata[13:2];
                    r_rd     <= s_axis_tdata[16:14];
                    r_b      <= s_axis_tdata[24:17];
                    r_status <= mmrb_pkg::ST_PHASE;
                    r_olen   <= '0;
                    r_ob     <= '0;
                    r_last   <= 1'b0;
                    r_k      <= '0;
                end
                mmrb_pkg::S_DISPATCH: begin
                    r_hbase <= r_read_pos[r_rd];
                    if (r_cmd == mmrb_pkg::CMD_POP_BEGIN && reader_ok
                        && r_pop_left[r_rd] == '0) r_status <= mmrb_pkg::ST_DATA;
                end
                mmrb_pkg::S_PB_DEC: begin
                    r_hbase  <= r_wpos;
                    r_h_cnt  <= 8'(readers_eff);
                    r_status <= mmrb_pkg::ST_FULL;
                    if (14'(span) + 14'(mmrb_pkg::HEADER_BYTES) > 14'(tail)) begin
                        if (r_rel != '0 && tail <= r_free) begin
                            r_h_id   <= 16'd0;
                            r_h_len  <= 16'(tail) - 16'(mmrb_pkg::HEADER_BYTES);
                            r_h_pad  <= 16'd0;
                            r_free   <= r_free - tail;
                            r_wpos   <= '0;
                            r_status <= mmrb_pkg::ST_WRAPPED;
                        end
                    end else if (14'(span) + 14'd1 < 14'(r_free)) begin
                        r_h_id      <= r_msgc;
                        r_h_len     <= 16'(r_len);
                        r_h_pad     <= 16'(pad);
                        r_free      <= r_free - span;
                        r_msgc      <= (r_msgc == 16'hFFFF) ? 16'd1 : r_msgc + 16'd1;
                        r_push_cur  <= r_wpos + AW'(mmrb_pkg::HEADER_BYTES);
                        r_push_left <= r_len;
                        r_push_span <= span;
                        if (r_len == '0) r_wpos <= r_wpos + span[AW-1:0];
                        r_status    <= mmrb_pkg::ST_ACCEPTED;
                    end
                end
                mmrb_pkg::S_HDR_WR: begin
                    r_k <= r_k + 4'd1;
                end
                mmrb_pkg::S_PUSH_WR: begin
                    r_push_cur  <= r_push_cur + AW'(1);
                    r_push_left <= r_push_left - AW'(1);
                    if (r_push_left == AW'(1)) r_wpos <= r_wpos + r_push_span[AW-1:0];
                    r_status    <= mmrb_pkg::ST_ACCEPTED;
                end
                mmrb_pkg::S_HDR_RD: begin
                    r_k <= r_k + 4'd1;
                    case (r_k)
                        4'd1: r_f_id[7:0]   <= ram_rdata;
                        4'd2: r_f_id[15:8]  <= ram_rdata;
                        4'd3: r_f_len[7:0]  <= ram_rdata;
                        4'd4: r_f_len[15:8] <= ram_rdata;
                        4'd5: r_f_pad[7:0]  <= ram_rdata;
                        4'd6: r_f_pad[15:8] <= ram_rdata;
                        4'd7: r_f_cnt       <= ram_rdata;
                        default: ;
                    endcase
                end
                mmrb_pkg::S_POP_DEC: begin
                    if (pb_dummy_pop) begin
                        if (cnt_dec == 8'd0) begin
                            r_free <= free_sat;
                            r_rel  <= '0;
                        end
                        r_read_pos[r_rd] <= '0;
                        r_status         <= mmrb_pkg::ST_DUMMY;
                    end else begin
                        if (r_cmd == mmrb_pkg::CMD_POP_BEGIN) begin
                            r_olen           <= r_f_len[mmrb_pkg::LENW-1:0];
                            r_pop_cur[r_rd]  <= r_hbase + AW'(mmrb_pkg::HEADER_BYTES);
                            r_pop_left[r_rd] <= r_f_len[mmrb_pkg::LENW-1:0];
                            r_status         <= mmrb_pkg::ST_READY;
                        end
                        if (!pb_plain_pop) begin
                            r_read_pos[r_rd] <= f_next;
                            if (cnt_dec == 8'd0) begin
                                r_free <= free_sat;
                                r_rel  <= f_next;
                            end
                        end
                    end
                end
                mmrb_pkg::S_PD_CAP: begin
                    r_ob             <= ram_rdata;
                    r_pop_cur[r_rd]  <= r_pop_cur[r_rd] + AW'(1);
                    r_pop_left[r_rd] <= r_pop_left[r_rd] - AW'(1);
                    r_status         <= mmrb_pkg::ST_DATA;
                    r_hbase          <= r_read_pos[r_rd];
                    r_k              <= '0;
                    if (r_pop_left[r_rd] == AW'(1)) r_last <= 1'b1;
                end
                mmrb_pkg::S_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {4'd0, r_free, r_ob, r_olen, r_status};
                        r_m_last  <= r_last;
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == mmrb_pkg::S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;
endmodule
`default_nettype wire
